### hdl/m4vt_pkg.sv
// Shared types and constants for the 4x4 matrix vector transform.
package m4vt_pkg;

  localparam int unsigned Q_W       = 32;           // Q16.16 word
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * Q_W;      // one coefficient times one component
  localparam int unsigned PAIR_W    = PROD_W + 1;   // sum of two products
  localparam int unsigned SUM_W     = PROD_W + 2;   // sum of four products
  localparam int unsigned VEC_N     = 4;
  localparam int unsigned REG_COUNT = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned IDX_W     = $clog2(REG_COUNT);

  typedef logic [Q_W-1:0]              q_word_t;
  typedef logic [VEC_N-1:0][Q_W-1:0]   q_vec_t;
  typedef logic [CFG_W-1:0]            cfg_word_t;
  typedef logic [IDX_W-1:0]            cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_ROW0_COLS01 = 3'd0;
  localparam cfg_idx_t REG_ROW0_COLS23 = 3'd1;
  localparam cfg_idx_t REG_ROW1_COLS01 = 3'd2;
  localparam cfg_idx_t REG_ROW1_COLS23 = 3'd3;
  localparam cfg_idx_t REG_ROW2_COLS01 = 3'd4;
  localparam cfg_idx_t REG_ROW2_COLS23 = 3'd5;
  localparam cfg_idx_t REG_ROW3_COLS01 = 3'd6;
  localparam cfg_idx_t REG_ROW3_COLS23 = 3'd7;

  // Identity matrix in Q16.16
  localparam cfg_word_t ONE_LO = 64'h0000_0000_0001_0000;
  localparam cfg_word_t ONE_HI = 64'h0001_0000_0000_0000;
  localparam cfg_word_t ZERO_W = 64'h0000_0000_0000_0000;

  localparam q_word_t SAT_MAX = 32'h7FFF_FFFF;
  localparam q_word_t SAT_MIN = 32'h8000_0000;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic prod;   // products
    logic pair;   // pairwise sums
    logic sum;    // row sums
    logic outp;   // shifted, saturated result
  } m4vt_load_t;

endpackage

### hdl/m4vt_vec_if.sv
// Request channel carrying one homogeneous Q16.16 vector.
interface m4vt_vec_if;
  logic               valid;
  logic               ready;
  m4vt_pkg::q_word_t  vec_x;
  m4vt_pkg::q_word_t  vec_y;
  m4vt_pkg::q_word_t  vec_z;
  m4vt_pkg::q_word_t  vec_w;

  modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                  input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                  output ready);
endinterface

### hdl/m4vt_res_if.sv
// Result channel carrying the transformed vector and the saturation flag.
interface m4vt_res_if;
  logic               valid;
  logic               ready;
  m4vt_pkg::q_word_t  res_x;
  m4vt_pkg::q_word_t  res_y;
  m4vt_pkg::q_word_t  res_z;
  m4vt_pkg::q_word_t  res_w;
  logic               clipped;

  modport source (output valid, output res_x, output res_y, output res_z, output res_w,
                  output clipped, input ready);
  modport sink   (input valid, input res_x, input res_y, input res_z, input res_w,
                  input clipped, output ready);
endinterface

### hdl/m4vt_row.sv
// One matrix row dot the vector: multiply, two adder levels, shift and saturate.
module m4vt_row (
  input  logic                 clk,
  input  m4vt_pkg::q_vec_t     coef,
  input  m4vt_pkg::q_vec_t     vec,
  input  m4vt_pkg::m4vt_load_t load,
  output m4vt_pkg::q_word_t    res,
  output logic                 clip
);
  import m4vt_pkg::*;

  logic signed [PROD_W-1:0] prod_r   [VEC_N];
  logic signed [PROD_W-1:0] prod_nxt [VEC_N];
  logic signed [PAIR_W-1:0] pair_r   [2];
  logic signed [PAIR_W-1:0] pair_nxt [2];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  q_word_t                  res_r;
  q_word_t                  res_nxt;
  logic                     clip_r;
  logic                     clip_nxt;
  logic [SUM_W-Q_W-FRAC_BITS:0] hi_bits;

  always_comb begin
    for (int n = 0; n < VEC_N; n++) begin
      prod_nxt[n] = $signed(coef[n]) * $signed(vec[n]);
    end
    for (int k = 0; k < 2; k++) begin
      pair_nxt[k] = PAIR_W'(prod_r[2*k]) + PAIR_W'(prod_r[2*k+1]);
    end
    sum_nxt = SUM_W'(pair_r[0]) + SUM_W'(pair_r[1]);
  end

  // Floor shift by FRAC_BITS; result fits when bits above bit 31 all match bit 31.
  assign hi_bits = sum_r[SUM_W-1:Q_W+FRAC_BITS-1];

  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      res_nxt  = sum_r[Q_W+FRAC_BITS-1:FRAC_BITS];
      clip_nxt = 1'b0;
    end else begin
      res_nxt  = sum_r[SUM_W-1] ? SAT_MIN : SAT_MAX;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load.prod) begin
      prod_r <= prod_nxt;
    end
    if (load.pair) begin
      pair_r <= pair_nxt;
    end
    if (load.sum) begin
      sum_r <= sum_nxt;
    end
    if (load.outp) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign res  = res_r;
  assign clip = clip_r;

endmodule

### hdl/matrix4_vector_transform.sv
// Top level of the 4x4 Q16.16 matrix vector transform.
//
// Usage: the 4x4 matrix sits in eight 64-bit registers written through
// cfg_we / cfg_index / cfg_wdata, two coefficients per register (column 2k in
// bits 31..0, column 2k+1 in bits 63..32). Write them only while no request is
// in flight. Vectors enter on in_chan (valid/ready), results leave on out_chan
// with the four row dot products, each floored by 2^16 and saturated to
// signed 32 bits; clipped flags that any component saturated.
// Pipeline: four register stages (products, pair sums, row sums, saturate); the
// accepting edge loads the products, and the result then passes through the pair
// sums, row sums and saturate registers to out_chan. Throughput: one vector per
// cycle unless out_chan stalls; sixteen 32x32 multipliers set the first stage.
// When out_chan stalls, stages fill bubbles first and then hold; in_chan.ready
// drops only when all four stages hold data. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// matrix.
module matrix4_vector_transform (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  m4vt_pkg::cfg_idx_t    cfg_index,
  input  m4vt_pkg::cfg_word_t   cfg_wdata,
  m4vt_vec_if.sink              in_chan,
  m4vt_res_if.source            out_chan
);
  import m4vt_pkg::*;

  cfg_word_t  cfg_r [REG_COUNT];
  logic [3:0] vld_r;
  logic [3:0] vld_nxt;
  m4vt_load_t load;
  q_vec_t     vec;
  q_vec_t     coef [VEC_N];
  q_word_t    res  [VEC_N];
  logic [VEC_N-1:0] clip;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_ROW0_COLS01] <= ONE_LO;
      cfg_r[REG_ROW0_COLS23] <= ZERO_W;
      cfg_r[REG_ROW1_COLS01] <= ONE_HI;
      cfg_r[REG_ROW1_COLS23] <= ZERO_W;
      cfg_r[REG_ROW2_COLS01] <= ZERO_W;
      cfg_r[REG_ROW2_COLS23] <= ONE_LO;
      cfg_r[REG_ROW3_COLS01] <= ZERO_W;
      cfg_r[REG_ROW3_COLS23] <= ONE_HI;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < VEC_N; r++) begin
      for (int c = 0; c < VEC_N; c++) begin
        coef[r][c] = cfg_r[2*r + c/2][(c%2)*Q_W +: Q_W];
      end
    end
  end

  assign vec[0] = in_chan.vec_x;
  assign vec[1] = in_chan.vec_y;
  assign vec[2] = in_chan.vec_z;
  assign vec[3] = in_chan.vec_w;

  // A stage loads when it is empty or the one after it moves on.
  assign load.outp = !vld_r[3] || out_chan.ready;
  assign load.sum  = !vld_r[2] || load.outp;
  assign load.pair = !vld_r[1] || load.sum;
  assign load.prod = !vld_r[0] || load.pair;

  assign in_chan.ready = load.prod;

  always_comb begin
    vld_nxt[0] = load.prod ? in_chan.valid : vld_r[0];
    vld_nxt[1] = load.pair ? vld_r[0]      : vld_r[1];
    vld_nxt[2] = load.sum  ? vld_r[1]      : vld_r[2];
    vld_nxt[3] = load.outp ? vld_r[2]      : vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar r = 0; r < VEC_N; r++) begin : g_row
    m4vt_row u_row (
      .clk  (clk),
      .coef (coef[r]),
      .vec  (vec),
      .load (load),
      .res  (res[r]),
      .clip (clip[r])
    );
  end

  assign out_chan.valid   = vld_r[3];
  assign out_chan.res_x   = res[0];
  assign out_chan.res_y   = res[1];
  assign out_chan.res_z   = res[2];
  assign out_chan.res_w   = res[3];
  assign out_chan.clipped = |clip;

  // Backpressure reaches the input only with every stage full.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> ((&vld_r) && !out_chan.ready))
    else $error("input blocked with a bubble in the pipeline");

  // A clipped result carries a saturated component.
  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.clipped) |->
      (out_chan.res_x == SAT_MAX || out_chan.res_x == SAT_MIN ||
       out_chan.res_y == SAT_MAX || out_chan.res_y == SAT_MIN ||
       out_chan.res_z == SAT_MAX || out_chan.res_z == SAT_MIN ||
       out_chan.res_w == SAT_MAX || out_chan.res_w == SAT_MIN))
    else $error("clipped flag without a saturated component");

  // An accepted request is in the product stage in the next cycle.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> vld_r[0])
    else $error("accepted request lost at the product stage");

  // A product stage entry moves to the pair stage when that stage loads.
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[0] && load.pair) |=> vld_r[1])
    else $error("request dropped between product and pair stages");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule

### verif/testbench.sv
// Self-checking bench for the 4x4 Q16.16 transform: directed table plus random vectors vs. a local model.
`timescale 1ns / 1ps

module testbench;
  import m4vt_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int IDLE_PCT       = 26;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;
  localparam int STALL_ITEM     = 130;
  localparam int STALL_CYCLES   = 60;
  localparam int PIPE_DEPTH     = 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int QUIET_PHASE    = 4;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 66'sd2147483647;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -66'sd2147483648;

  typedef struct packed {
    q_word_t x;
    q_word_t y;
    q_word_t z;
    q_word_t w;
  } vec4_t;

  typedef struct packed {
    vec4_t v;
    logic  clipped;
  } xform_out_t;

  typedef enum logic [2:0] {
    MAT_IDENT,
    MAT_SAT_POS,
    MAT_SAT_NEG,
    MAT_MIXED,
    MAT_RANDOM
  } mat_kind_t;

  typedef struct packed {
    mat_kind_t  mat;
    vec4_t      vec;
    logic       typed;
    xform_out_t want;
  } dir_row_t;

  localparam q_word_t Q0   = 32'h0000_0000;
  localparam q_word_t ONE  = 32'h0001_0000;
  localparam q_word_t EPS  = 32'h0000_0001;
  localparam q_word_t NEPS = 32'hFFFF_FFFF;
  localparam xform_out_t NO_WANT = '0;

  localparam int DIR_N = 20;
  localparam dir_row_t DIR_TABLE [DIR_N] = '{
    // identity after reset: output equals input
    '{MAT_IDENT, {Q0, Q0, Q0, Q0}, 1'b1, {Q0, Q0, Q0, Q0, 1'b0}},
    '{MAT_IDENT, {SAT_MAX, SAT_MIN, EPS, NEPS}, 1'b1, {SAT_MAX, SAT_MIN, EPS, NEPS, 1'b0}},
    '{MAT_IDENT, {SAT_MIN, SAT_MAX, 32'hFFFF0000, ONE}, 1'b1,
      {SAT_MIN, SAT_MAX, 32'hFFFF0000, ONE, 1'b0}},
    '{MAT_IDENT, {32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0}, 1'b1,
      {32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0}},
    // every coefficient at the positive extreme
    '{MAT_SAT_POS, {ONE, ONE, ONE, ONE}, 1'b1, {SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}},
    '{MAT_SAT_POS, {SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b1,
      {SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1}},
    '{MAT_SAT_POS, {Q0, Q0, Q0, Q0}, 1'b1, {Q0, Q0, Q0, Q0, 1'b0}},
    // sum is -0x7FFFFFFF, floors to -32768
    '{MAT_SAT_POS, {SAT_MAX, SAT_MIN, Q0, Q0}, 1'b1,
      {32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 1'b0}},
    '{MAT_SAT_POS, {EPS, Q0, Q0, Q0}, 1'b1,
      {32'h00007FFF, 32'h00007FFF, 32'h00007FFF, 32'h00007FFF, 1'b0}},
    // every coefficient at the negative extreme
    '{MAT_SAT_NEG, {SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN}, 1'b1,
      {SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1}},
    '{MAT_SAT_NEG, {SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX}, 1'b1,
      {SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1}},
    '{MAT_SAT_NEG, {EPS, Q0, Q0, Q0}, 1'b1,
      {32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 1'b0}},
    '{MAT_SAT_NEG, {NEPS, Q0, Q0, Q0}, 1'b1,
      {32'h00008000, 32'h00008000, 32'h00008000, 32'h00008000, 1'b0}},
    '{MAT_SAT_NEG, {SAT_MAX, Q0, Q0, Q0}, 1'b1, {SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 1'b1}},
    // fractional and mixed-sign coefficients, predicted
    '{MAT_MIXED, {EPS, EPS, EPS, EPS}, 1'b0, NO_WANT},
    '{MAT_MIXED, {SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN}, 1'b0, NO_WANT},
    '{MAT_MIXED, {NEPS, NEPS, NEPS, NEPS}, 1'b0, NO_WANT},
    '{MAT_MIXED, {ONE, ONE, ONE, ONE}, 1'b0, NO_WANT},
    '{MAT_MIXED, {SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX}, 1'b0, NO_WANT},
    '{MAT_MIXED, {32'h0ABCDEF0, 32'hF5432110, 32'h00020000, 32'hFFFE0000}, 1'b0, NO_WANT}
  };

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_word_t cfg_wdata;

  m4vt_vec_if vec_bus ();
  m4vt_res_if res_bus ();

  matrix4_vector_transform uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (vec_bus),
    .out_chan (res_bus)
  );

  cfg_word_t  mat_regs  [REG_COUNT];   // mirror of the coefficient registers
  cfg_word_t  next_regs [REG_COUNT];
  xform_out_t want_q [$];
  int         mismatch_count = 0;
  bit         stall_req = 1'b0;
  bit         quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic xform_out_t transform_vec(vec4_t v);
    q_word_t                 comp [VEC_N];
    q_word_t                 res  [VEC_N];
    q_word_t                 coef;
    cfg_word_t               word;
    logic signed [SUM_W-1:0] acc, a, b, shifted;
    xform_out_t              r;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    comp[3] = v.w;
    r = '0;
    for (int row = 0; row < VEC_N; row++) begin
      acc = '0;
      for (int col = 0; col < VEC_N; col++) begin
        word = mat_regs[row * 2 + col / 2];
        coef = (col % 2 == 1) ? word[63:32] : word[31:0];
        a = $signed(coef);
        b = $signed(comp[col]);
        acc = acc + a * b;
      end
      shifted = acc >>> FRAC_BITS;   // floor
      if (shifted > SUM_MAX) begin
        shifted = SUM_MAX;
        r.clipped = 1'b1;
      end else if (shifted < SUM_MIN) begin
        shifted = SUM_MIN;
        r.clipped = 1'b1;
      end
      res[row] = shifted[Q_W-1:0];
    end
    r.v = {res[0], res[1], res[2], res[3]};
    return r;
  endfunction

  function automatic q_word_t rand_comp();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return Q0;
      3: return NEPS;
      4, 5, 6: return {{12{r[19]}}, r[19:0]};
      default: return r;
    endcase
  endfunction

  function automatic q_word_t rand_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return ONE;
      1: return 32'hFFFF_0000;
      2: return Q0;
      3: return SAT_MAX;
      4: return SAT_MIN;
      5, 6, 7, 8: return {{13{r[18]}}, r[18:0]};
      default: return r;
    endcase
  endfunction

  function automatic void fill_matrix(mat_kind_t kind);
    for (int i = REG_ROW0_COLS01; i <= REG_ROW3_COLS23; i++) begin
      case (kind)
        MAT_SAT_POS: next_regs[i] = {SAT_MAX, SAT_MAX};
        MAT_SAT_NEG: next_regs[i] = {SAT_MIN, SAT_MIN};
        MAT_RANDOM:  next_regs[i] = {rand_coef(), rand_coef()};
        default:     next_regs[i] = ZERO_W;
      endcase
    end
    if (kind == MAT_IDENT) begin
      next_regs[REG_ROW0_COLS01] = ONE_LO;
      next_regs[REG_ROW1_COLS01] = ONE_HI;
      next_regs[REG_ROW2_COLS23] = ONE_LO;
      next_regs[REG_ROW3_COLS23] = ONE_HI;
    end else if (kind == MAT_MIXED) begin
      next_regs[REG_ROW0_COLS01] = 64'hFFFF8000_00008000;
      next_regs[REG_ROW0_COLS23] = 64'h00018000_FFFFFFFF;
      next_regs[REG_ROW1_COLS01] = 64'h7FFFFFFF_80000000;
      next_regs[REG_ROW1_COLS23] = 64'h00000000_00010000;
      next_regs[REG_ROW2_COLS01] = 64'hFFFF0000_00000001;
      next_regs[REG_ROW2_COLS23] = 64'h12345678_9ABCDEF0;
      next_regs[REG_ROW3_COLS01] = 64'h00000000_00000000;
      next_regs[REG_ROW3_COLS23] = 64'hFFFFFFFF_FFFFFFFF;
    end
  endfunction

  // Called at a falling edge with the pipeline drained; skipped registers keep their old words.
  task automatic write_matrix(input bit every);
    for (int i = REG_ROW0_COLS01; i <= REG_ROW3_COLS23; i++) begin
      if (every || $urandom_range(3) != 0) begin
        cfg_we    <= 1'b1;
        cfg_index <= cfg_idx_t'(i);
        cfg_wdata <= next_regs[i];
        mat_regs[i] = next_regs[i];
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pause_for_results();
    vec_bus.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Entered at a falling edge where valid has not been assigned yet.
  task automatic send_vec(input vec4_t v, input bit typed, input xform_out_t typed_want);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      vec_bus.valid <= 1'b0;
      @(negedge clk);
    end
    vec_bus.valid <= 1'b1;
    vec_bus.vec_x <= v.x;
    vec_bus.vec_y <= v.y;
    vec_bus.vec_z <= v.z;
    vec_bus.vec_w <= v.w;
    @(posedge clk);
    while (!vec_bus.ready) @(posedge clk);
    want_q.push_back(typed ? typed_want : transform_vec(v));
    @(negedge clk);
  endtask

  function automatic void check_field(string name, q_word_t want, q_word_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    xform_out_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (want_q.size() == 0) begin
        $display("%0t: result with no request pending: expected none, got %h %h %h %h %b",
                 $time, res_bus.res_x, res_bus.res_y, res_bus.res_z, res_bus.res_w,
                 res_bus.clipped);
        mismatch_count++;
      end else begin
        want = want_q.pop_front();
        check_field("res_x", want.v.x, res_bus.res_x);
        check_field("res_y", want.v.y, res_bus.res_y);
        check_field("res_z", want.v.z, res_bus.res_z);
        check_field("res_w", want.v.w, res_bus.res_w);
        check_field("clipped", q_word_t'(want.clipped), q_word_t'(res_bus.clipped));
      end
    end
  end

  // Result side back-pressure, with one long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      res_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((vec_bus.valid && vec_bus.ready) || (res_bus.valid && res_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    vec4_t     v;
    mat_kind_t cur_kind;
    int        item;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_ROW0_COLS01;
    cfg_wdata     = ZERO_W;
    vec_bus.valid = 1'b0;
    vec_bus.vec_x = Q0;
    vec_bus.vec_y = Q0;
    vec_bus.vec_z = Q0;
    vec_bus.vec_w = Q0;
    fill_matrix(MAT_IDENT);
    mat_regs = next_regs;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cur_kind = MAT_IDENT;
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TABLE[i].mat != cur_kind) begin
        cur_kind = DIR_TABLE[i].mat;
        pause_for_results();
        fill_matrix(cur_kind);
        write_matrix(1'b1);
      end
      send_vec(DIR_TABLE[i].vec, DIR_TABLE[i].typed, DIR_TABLE[i].want);
    end

    item = 0;
    for (int p = 0; p < PHASES; p++) begin
      pause_for_results();
      case (p)
        3:       fill_matrix(MAT_IDENT);
        6:       fill_matrix(MAT_SAT_NEG);
        default: fill_matrix(MAT_RANDOM);
      endcase
      write_matrix(p % 2 == 0);
      quiet = (p == QUIET_PHASE);
      repeat (PHASE_ITEMS) begin
        if (item == STALL_ITEM) stall_req = 1'b1;
        v = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        send_vec(v, 1'b0, NO_WANT);
        item++;
      end
    end
    quiet = 1'b0;
    pause_for_results();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### matrix4_vector_transform.f
hdl/m4vt_pkg.sv
hdl/m4vt_vec_if.sv
hdl/m4vt_res_if.sv
hdl/m4vt_row.sv
hdl/matrix4_vector_transform.sv
verif/testbench.sv
